[src/isort_pkg.sv]
// shared constants and types of the integer array sorter
package isort_pkg;

   localparam int DEPTH = 16;
   localparam int DATA_W = 32;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef logic signed [DATA_W-1:0] elem_type;
   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

[src/isort_if.sv]
// request and response channel interfaces of the integer array sorter
interface isort_req_if;
   logic                valid;
   logic                ready;
   isort_pkg::elem_type value;
   logic                last_in;

   modport source (output valid, output value, output last_in, input ready);
   modport sink (input valid, input value, input last_in, output ready);
endinterface

interface isort_rsp_if;
   logic                valid;
   logic                ready;
   isort_pkg::elem_type sorted_value;
   logic                last_out;
   logic                overflow;

   modport source (output valid, output sorted_value, output last_out, output overflow,
                   input ready);
   modport sink (input valid, input sorted_value, input last_out, input overflow,
                 output ready);
endinterface

[src/isort_cell.sv]
// one insertion cell of the sorting chain
module isort_cell (
   input  logic                     clock,
   input  isort_pkg::cell_ctrl_type ctrl,
   input  isort_pkg::elem_type      new_value,
   input  logic                     occupied,
   input  logic                     left_lt,
   input  isort_pkg::elem_type      left_value,
   input  isort_pkg::elem_type      right_value,
   output logic                     lt,
   output isort_pkg::elem_type      value
);

   isort_pkg::elem_type value_ff;
   isort_pkg::elem_type value_in;

   // new element goes ahead of this cell's content, empty cells act as +infinity
   assign lt = !occupied || (new_value < value_ff);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.shift) begin
         value_in = right_value;
      end else if (ctrl.insert) begin
         if (left_lt) begin
            value_in = left_value;
         end else if (lt) begin
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[src/integer_array_sorter_core.sv]
// top level of the integer array sorter: insertion cell chain and control
//
// usage:
//   req_ch carries one signed 32-bit element per transaction; last_in marks the
//   final element of a set. each element is dropped into a chain of DEPTH
//   insertion cells that keeps the set in ascending order as it arrives, so
//   one element is taken every cycle while a set is loading.
//   once the closing element is taken the chain drains through rsp_ch,
//   smallest value first, one transaction per cycle while rsp_ch.ready is
//   high, with last_out on the final one. the first result is valid the
//   cycle after the closing element. elements arriving while all DEPTH cells
//   are full are dropped and overflow is set on every result of that set.
//   req_ch.ready is low while draining, set by the state register, so a new
//   set is taken only once the previous one has drained.
//   the head cell is the output register: when rsp_ch.ready is low the chain
//   holds and the result stays on the port.
//   reset (synchronous, active high) clears the fill count and overflow flag
//   and returns to loading; cell contents are not cleared, empty cells are
//   marked by the fill count
module integer_array_sorter_core (
   input  logic        clock,
   input  logic        reset,
   isort_req_if.sink   req_ch,
   isort_rsp_if.source rsp_ch
);

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   state_type            state_ff, state_in;
   isort_pkg::count_type count_ff, count_in;
   logic                 dropped_ff, dropped_in;

   isort_pkg::cell_ctrl_type ctrl;
   isort_pkg::elem_type      cell_value [isort_pkg::DEPTH];
   logic                     cell_lt    [isort_pkg::DEPTH];

   logic req_fire;
   logic rsp_fire;
   logic full;

   assign req_ch.ready = (state_ff == ST_FILL);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign full = (count_ff == isort_pkg::count_type'(isort_pkg::DEPTH));

   // insert only while there is room, shift toward the head on each result taken
   assign ctrl.insert = req_fire && !full;
   assign ctrl.shift = rsp_fire;

   genvar gi;
   generate
      for (gi = 0; gi < isort_pkg::DEPTH; gi++) begin : g_cell
         logic                occ;
         logic                left_lt;
         isort_pkg::elem_type left_value;
         isort_pkg::elem_type right_value;

         assign occ = isort_pkg::count_type'(gi) < count_ff;
         if (gi == 0) begin : g_head
            assign left_lt = 1'b0;
            assign left_value = cell_value[gi];
         end else begin : g_body
            assign left_lt = cell_lt[gi-1];
            assign left_value = cell_value[gi-1];
         end
         if (gi == isort_pkg::DEPTH - 1) begin : g_tail
            assign right_value = cell_value[gi];
         end else begin : g_inner
            assign right_value = cell_value[gi+1];
         end

         isort_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .new_value   (req_ch.value),
            .occupied    (occ),
            .left_lt     (left_lt),
            .left_value  (left_value),
            .right_value (right_value),
            .lt          (cell_lt[gi]),
            .value       (cell_value[gi])
         );
      end
   endgenerate

   assign rsp_ch.valid = (state_ff == ST_DRAIN);
   assign rsp_ch.sorted_value = cell_value[0];
   assign rsp_ch.last_out = (count_ff == isort_pkg::count_type'(1));
   assign rsp_ch.overflow = dropped_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_fire) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + isort_pkg::count_type'(1);
               end
               if (req_ch.last_in) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_fire) begin
               count_in = count_ff - isort_pkg::count_type'(1);
               if (rsp_ch.last_out) begin
                  state_in = ST_FILL;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         count_ff <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         dropped_ff <= dropped_in;
      end
   end

`ifndef SYNTHESIS
   // fill count never exceeds the number of cells
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= isort_pkg::count_type'(isort_pkg::DEPTH))
      else $error("fill count above capacity");

   // a drain never starts or runs with an empty chain
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (count_ff != '0))
      else $error("draining an empty chain");

   // the final result returns the block to loading with a clear chain
   a_last_ends_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last_out) |=> (req_ch.ready && count_ff == '0 && !dropped_ff))
      else $error("set not closed after final result");

   // overflow can only be flagged once the chain is full
   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      $rose(dropped_ff) |-> $past(full))
      else $error("element dropped while room remained");
`endif

endmodule

[dv/isort_order_check.sv]
// watches both channels of the sorter, predicts each sorted run and compares results
module isort_order_check (
   input  logic  clock,
   input  logic  reset,
   isort_req_if  req_ch,
   isort_rsp_if  rsp_ch,
   output int    fail_count,
   output int    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      isort_pkg::elem_type value;
      logic                last;
      logic                overflow;
   } sorted_item_type;

   isort_pkg::elem_type set_store [isort_pkg::DEPTH];
   int                  set_fill;
   logic                set_dropped;
   sorted_item_type     sorted_q [$];
   sorted_item_type     head_item;
   int                  error_count = 0;

   assign fail_count = error_count;

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // add one element to the open set; on the closing element queue the sorted run
   task automatic take_element(input isort_pkg::elem_type v, input logic last);
      isort_pkg::elem_type run [isort_pkg::DEPTH];
      isort_pkg::elem_type key;
      int                  i;
      int                  j;
      if (set_fill < isort_pkg::DEPTH) begin
         set_store[set_fill] = v;
         set_fill++;
      end else begin
         set_dropped = 1'b1;
      end
      if (last) begin
         // insertion sort, signed compare
         for (i = 0; i < set_fill; i++) begin
            key = set_store[i];
            j = i;
            while (j > 0 && run[j-1] > key) begin
               run[j] = run[j-1];
               j--;
            end
            run[j] = key;
         end
         for (i = 0; i < set_fill; i++)
            sorted_q.push_back('{value: run[i], last: (i == set_fill - 1),
                                 overflow: set_dropped});
         set_fill = 0;
         set_dropped = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         set_fill = 0;
         set_dropped = 1'b0;
         sorted_q.delete();
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (sorted_q.size() == 0) begin
               report_error($sformatf("unexpected result value %0d", rsp_ch.sorted_value));
            end else begin
               head_item = sorted_q.pop_front();
               if (rsp_ch.sorted_value !== head_item.value)
                  report_error($sformatf("sorted_value expected %0d got %0d",
                                         head_item.value, rsp_ch.sorted_value));
               if (rsp_ch.last_out !== head_item.last)
                  report_error($sformatf("last_out expected %b got %b",
                                         head_item.last, rsp_ch.last_out));
               if (rsp_ch.overflow !== head_item.overflow)
                  report_error($sformatf("overflow expected %b got %b",
                                         head_item.overflow, rsp_ch.overflow));
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            take_element(req_ch.value, req_ch.last_in);
      end
      pending <= sorted_q.size();
   end

endmodule

[dv/testbench.sv]
// top of the sorter testbench: clock, reset, stimulus, receiver stalls and verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // signed extremes of an element
   localparam isort_pkg::elem_type ELEM_MAX = {1'b0, {(isort_pkg::DATA_W-1){1'b1}}};
   localparam isort_pkg::elem_type ELEM_MIN = {1'b1, {(isort_pkg::DATA_W-1){1'b0}}};

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   items_sent;
   int   random_sent;
   int   set_size;

   isort_req_if req_ch ();
   isort_rsp_if rsp_ch ();

   integer_array_sorter_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   isort_order_check u_order_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit, well above the slowest legal run
   initial begin
      #2_000_000;
      $display("integer_array_sorter_core test failed");
      $finish;
   end

   // idle length: mostly none, often a few cycles, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // element mix: full random words, small values that collide, and both extremes
   function automatic isort_pkg::elem_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return isort_pkg::elem_type'($urandom);
      if (r < 75)
         return isort_pkg::elem_type'(int'($urandom_range(0, 6)) - 3);
      if (r < 87)
         return ELEM_MAX;
      return ELEM_MIN;
   endfunction

   // one transaction on req_ch; valid stays high afterwards so back to back
   // elements need no second assignment in the same step
   task automatic send_element(input isort_pkg::elem_type v, input logic last,
                               input bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.value   <= v;
      req_ch.last_in <= last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      items_sent++;
   endtask

   task automatic send_set(input int size);
      bit no_gaps;
      int i;
      // about one set in four streams with no idle cycles at all
      no_gaps = ($urandom_range(0, 3) == 0);
      for (i = 0; i < size; i++)
         send_element(pick_value(), i == size - 1, no_gaps);
   endtask

   // hold off the sender until every predicted result has been seen;
   // pending is a registered copy of the queue size, so look only after the next edge
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // receiver side: random stalls, with calm stretches of steady ready
   initial begin
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm_left > 0) begin
            calm_left--;
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 39) == 0)
               calm_left = $urandom_range(30, 80);
            else
               stall_left = pick_gap();
         end
      end
   end

   initial begin
      items_sent = 0;
      random_sent = 0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.value   <= '0;
      req_ch.last_in <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single element sets at both extremes
      send_element(ELEM_MAX, 1'b1, 1'b0);
      send_element(ELEM_MIN, 1'b1, 1'b0);

      // sign boundary, both extremes twice so equal values sit side by side
      send_element(isort_pkg::elem_type'(0), 1'b0, 1'b0);
      send_element(isort_pkg::elem_type'(-1), 1'b0, 1'b0);
      send_element(isort_pkg::elem_type'(1), 1'b0, 1'b0);
      send_element(ELEM_MIN, 1'b0, 1'b0);
      send_element(ELEM_MAX, 1'b0, 1'b0);
      send_element(ELEM_MIN, 1'b0, 1'b0);
      send_element(ELEM_MAX, 1'b1, 1'b0);

      // two equal negatives
      send_element(isort_pkg::elem_type'(-7), 1'b0, 1'b0);
      send_element(isort_pkg::elem_type'(-7), 1'b1, 1'b0);

      // strictly descending, back to back
      send_element(isort_pkg::elem_type'(3), 1'b0, 1'b1);
      send_element(isort_pkg::elem_type'(2), 1'b0, 1'b1);
      send_element(isort_pkg::elem_type'(1), 1'b0, 1'b1);
      send_element(isort_pkg::elem_type'(0), 1'b1, 1'b1);

      // quiet point: everything drained before the random part
      wait_drained();

      // overflow where the closing element itself is dropped, then an exactly full set
      send_set(isort_pkg::DEPTH + 1);
      send_set(isort_pkg::DEPTH);

      // random sets: mostly small, some full and some overflowing
      random_sent = 2 * isort_pkg::DEPTH + 1;
      while (random_sent < 100) begin
         case ($urandom_range(0, 9))
            0:       set_size = isort_pkg::DEPTH;
            1:       set_size = isort_pkg::DEPTH + $urandom_range(1, 4);
            default: set_size = $urandom_range(1, 8);
         endcase
         send_set(set_size);
         random_sent += set_size;
         if ($urandom_range(0, 7) == 0)
            wait_drained();
      end

      // let the last run drain, then a tail to catch stray results
      wait_drained();
      repeat (2 * isort_pkg::DEPTH + 20) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("integer_array_sorter_core test passed");
      else
         $display("integer_array_sorter_core test failed");
      $finish;
   end

endmodule
